// ----- hw/rtl/lh2_pkg.sv -----
// ----------------------------------------------------------------------------
// lh2_pkg
// Types, constants, round functions and byte normalization of the lookup3 hashlittle2 engine.
// ----------------------------------------------------------------------------
package lh2_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int CHUNK_W = 4;

   localparam logic [WORD_W-1:0]  INIT_CONST  = 32'hDEAD_BEEF;
   localparam logic [CHUNK_W-1:0] CHUNK_BYTES = 4'd12;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET    = 8'h20;

   // lane select by chunk position bits [3:2]
   localparam logic [1:0] LANE_A = 2'd0;
   localparam logic [1:0] LANE_B = 2'd1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
   } lanes_type;

   function automatic word_type rotl(input word_type x, input int k);
      rotl = (x << k) | (x >> (WORD_W - k));
   endfunction

   function automatic lanes_type mix_rounds(input lanes_type s);
      word_type a;
      word_type b;
      word_type c;
      a = s.a; b = s.b; c = s.c;
      a = a - c; a = a ^ rotl(c, 4);  c = c + b;
      b = b - a; b = b ^ rotl(a, 6);  a = a + c;
      c = c - b; c = c ^ rotl(b, 8);  b = b + a;
      a = a - c; a = a ^ rotl(c, 16); c = c + b;
      b = b - a; b = b ^ rotl(a, 19); a = a + c;
      c = c - b; c = c ^ rotl(b, 4);  b = b + a;
      mix_rounds = '{a: a, b: b, c: c};
   endfunction

   function automatic lanes_type final_rounds(input lanes_type s);
      word_type a;
      word_type b;
      word_type c;
      a = s.a; b = s.b; c = s.c;
      c = c ^ b; c = c - rotl(b, 14);
      a = a ^ c; a = a - rotl(c, 11);
      b = b ^ a; b = b - rotl(a, 25);
      c = c ^ b; c = c - rotl(b, 16);
      a = a ^ c; a = a - rotl(c, 4);
      b = b ^ a; b = b - rotl(a, 14);
      c = c ^ b; c = c - rotl(b, 24);
      final_rounds = '{a: a, b: b, c: c};
   endfunction

   function automatic logic [BYTE_W-1:0] normalize_byte(input logic [BYTE_W-1:0] ch);
      if (ch == CHAR_SLASH) begin
         normalize_byte = CHAR_BACKSLASH;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         normalize_byte = ch - CASE_OFFSET;
      end else begin
         normalize_byte = ch;
      end
   endfunction

endpackage

// ----- hw/rtl/lh2_channels.sv -----
// ----------------------------------------------------------------------------
// lh2_channels
// Valid/ready channels of the hash engine: request, response and csr write.
// ----------------------------------------------------------------------------
interface lh2_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lh2_pkg::WORD_W-1:0]  msg_length;
   logic [lh2_pkg::WORD_W-1:0]  seed_primary;
   logic [lh2_pkg::WORD_W-1:0]  seed_secondary;
   logic [lh2_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, kind, msg_length, seed_primary, seed_secondary,
                   data_byte, input ready);
   modport sink   (input valid, kind, msg_length, seed_primary, seed_secondary,
                   data_byte, output ready);
endinterface

interface lh2_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lh2_pkg::WORD_W-1:0]  hash_primary;
   logic [lh2_pkg::WORD_W-1:0]  hash_secondary;

   modport source (output valid, hash_primary, hash_secondary, input ready);
   modport sink   (input valid, hash_primary, hash_secondary, output ready);
endinterface

interface lh2_csr_if;
   logic valid;
   logic ready;
   logic normalize_path_mode;

   modport source (output valid, normalize_path_mode, input ready);
   modport sink   (input valid, normalize_path_mode, output ready);
endinterface

// ----- hw/rtl/lookup3_hashlittle2_engine.sv -----
// ----------------------------------------------------------------------------
// lookup3_hashlittle2_engine
// Streams one message a word at a time and returns the hashlittle2 pair.
//
// req_chan takes start words (length and two seeds) and byte words. One word
// is taken per cycle, start or byte, while req_ready is high; a chunk mix runs
// in the same cycle as the twelfth byte of a chunk. Byte words with no message
// open are dropped. rsp_chan carries hash_primary (lane c) and hash_secondary
// (lane b) once per message, from the final stage (final rounds) through the
// response register; a zero-length start word skips the final rounds. csr_chan
// writes normalize_path_mode and is always ready; the user must see that it is
// written only while the engine is idle, as the engine does not enforce it.
// A full response register with rsp_ready low holds its word; the final stage
// behind it then fills, and while both are full req_ready stays low for every
// word, start or byte, until the response register drains.
// Reset clears lanes_ff, closes any message and sets normalize_path_mode.
// ----------------------------------------------------------------------------
module lookup3_hashlittle2_engine (
   input  logic          clock,
   input  logic          reset,
   lh2_req_if.sink       req_chan,
   lh2_rsp_if.source     rsp_chan,
   lh2_csr_if.sink       csr_chan
);

   // ---- state ----------------------------------------------------------
   lh2_pkg::lanes_type                 lanes_ff, lanes_in;
   lh2_pkg::word_type                  remain_ff, remain_in;
   logic [lh2_pkg::CHUNK_W-1:0]        chunk_pos_ff, chunk_pos_in;
   logic                               open_ff, open_in;
   logic                               norm_mode_ff, norm_mode_in;

   // final-round stage
   logic                               fin_valid_ff, fin_valid_in;
   logic                               fin_run_ff, fin_run_in;
   lh2_pkg::lanes_type                 fin_lanes_ff, fin_lanes_in;

   // response register
   logic                               rsp_valid_ff, rsp_valid_in;
   lh2_pkg::word_type                  rsp_primary_ff, rsp_primary_in;
   lh2_pkg::word_type                  rsp_secondary_ff, rsp_secondary_in;

   // ---- handshakes -----------------------------------------------------
   logic out_free;
   logic fin_advance;
   logic req_fire;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign fin_advance = fin_valid_ff && out_free;
   // accept while the final stage is empty or draining this cycle
   assign req_chan.ready = !fin_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.hash_primary   = rsp_primary_ff;
   assign rsp_chan.hash_secondary = rsp_secondary_ff;

   // ---- start word -----------------------------------------------------
   lh2_pkg::word_type  init_word;
   lh2_pkg::lanes_type init_lanes;

   assign init_word  = lh2_pkg::INIT_CONST + req_chan.msg_length + req_chan.seed_primary;
   assign init_lanes = '{a: init_word, b: init_word, c: init_word + req_chan.seed_secondary};

   // ---- byte word ------------------------------------------------------
   logic [lh2_pkg::BYTE_W-1:0]  byte_val;
   logic [lh2_pkg::CHUNK_W-1:0] pos;
   logic [lh2_pkg::CHUNK_W-1:0] pos_next;
   lh2_pkg::word_type           byte_word;
   lh2_pkg::lanes_type          added_lanes;
   lh2_pkg::word_type           remain_dec;
   logic                        last_byte;
   logic                        chunk_full;

   always_comb begin
      byte_val = norm_mode_ff ? lh2_pkg::normalize_byte(req_chan.data_byte)
                              : req_chan.data_byte;
      pos      = (chunk_pos_ff >= lh2_pkg::CHUNK_BYTES) ? '0 : chunk_pos_ff;
      pos_next = pos + 4'd1;
      // little-endian placement within the selected lane
      byte_word = lh2_pkg::word_type'(byte_val) << {pos[1:0], 3'b000};
      added_lanes = lanes_ff;
      case (pos[3:2])
         lh2_pkg::LANE_A: added_lanes.a = lanes_ff.a + byte_word;
         lh2_pkg::LANE_B: added_lanes.b = lanes_ff.b + byte_word;
         default:         added_lanes.c = lanes_ff.c + byte_word;
      endcase
      remain_dec = remain_ff - 32'd1;
      last_byte  = (remain_dec == '0);
      chunk_full = (pos_next == lh2_pkg::CHUNK_BYTES);
   end

   // ---- next state -----------------------------------------------------
   always_comb begin
      lanes_in     = lanes_ff;
      remain_in    = remain_ff;
      chunk_pos_in = chunk_pos_ff;
      open_in      = open_ff;
      norm_mode_in = norm_mode_ff;
      fin_valid_in = fin_advance ? 1'b0 : fin_valid_ff;
      fin_run_in   = fin_run_ff;
      fin_lanes_in = fin_lanes_ff;

      if (csr_chan.valid) begin
         norm_mode_in = csr_chan.normalize_path_mode;
      end

      if (req_fire) begin
         if (req_chan.kind == lh2_pkg::KIND_START) begin
            // a start abandons any open message
            lanes_in     = init_lanes;
            remain_in    = req_chan.msg_length;
            chunk_pos_in = '0;
            open_in      = (req_chan.msg_length != '0);
            if (req_chan.msg_length == '0) begin
               fin_valid_in = 1'b1;
               fin_run_in   = 1'b0;
               fin_lanes_in = init_lanes;
            end
         end else if (open_ff) begin
            remain_in = remain_dec;
            if (last_byte) begin
               lanes_in     = added_lanes;
               chunk_pos_in = '0;
               open_in      = 1'b0;
               fin_valid_in = 1'b1;
               fin_run_in   = 1'b1;
               fin_lanes_in = added_lanes;
            end else if (chunk_full) begin
               lanes_in     = lh2_pkg::mix_rounds(added_lanes);
               chunk_pos_in = '0;
            end else begin
               lanes_in     = added_lanes;
               chunk_pos_in = pos_next;
            end
         end
      end
   end

   // ---- final rounds and response register --------------------------------
   lh2_pkg::lanes_type fin_result;

   always_comb begin
      fin_result       = fin_run_ff ? lh2_pkg::final_rounds(fin_lanes_ff) : fin_lanes_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_primary_in   = rsp_primary_ff;
      rsp_secondary_in = rsp_secondary_ff;
      if (fin_advance) begin
         rsp_valid_in     = 1'b1;
         rsp_primary_in   = fin_result.c;
         rsp_secondary_in = fin_result.b;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---- registers ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff     <= '0;
         remain_ff    <= '0;
         chunk_pos_ff <= '0;
         open_ff      <= 1'b0;
         norm_mode_ff <= 1'b1;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lanes_ff     <= lanes_in;
         remain_ff    <= remain_in;
         chunk_pos_ff <= chunk_pos_in;
         open_ff      <= open_in;
         norm_mode_ff <= norm_mode_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_run_ff       <= fin_run_in;
      fin_lanes_ff     <= fin_lanes_in;
      rsp_primary_ff   <= rsp_primary_in;
      rsp_secondary_ff <= rsp_secondary_in;
   end

   // ---- assertions -----------------------------------------------------
`ifndef NO_ASSERTIONS
   a_open_has_bytes : assert property (@(posedge clock) disable iff (reset)
      open_ff |-> remain_ff != '0)
      else $error("message open with no bytes remaining");

   a_pos_in_chunk : assert property (@(posedge clock) disable iff (reset)
      chunk_pos_ff < lh2_pkg::CHUNK_BYTES)
      else $error("chunk position out of range");

   a_closed_pos_zero : assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> chunk_pos_ff == '0)
      else $error("chunk position not cleared with no message open");

   a_stray_byte_dropped : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.kind == lh2_pkg::KIND_BYTE && !open_ff)
      |=> $stable(lanes_ff) && $stable(remain_ff))
      else $error("byte with no open message changed state");

   a_fin_holds_on_stall : assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !out_free) |=> fin_valid_ff && $stable(fin_lanes_ff))
      else $error("final stage lost a result during a stall");
`endif

endmodule
